/* design/log_block_ack_nack_receiver_macros.svh */
// Assertion macros shared by the log block ack/nack receiver RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LOG_BLOCK_ACK_NACK_RECEIVER_MACROS_SVH
`define LOG_BLOCK_ACK_NACK_RECEIVER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define LBANR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define LBANR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

/* design/lbanr_pkg.sv */
// Types and constants of the log block ack/nack receiver.
// No dependencies; imported by the top level, the front end and the back end.
package lbanr_pkg;

    localparam int SEQ_W      = 32;
    localparam int ACTION_W   = 3;
    localparam int KIND_W     = 2;
    localparam int GAP_W      = 8;
    localparam int BURST_W    = 5;
    localparam int SIL_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // input actions
    localparam logic [ACTION_W-1:0] ACT_DATA    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DRAIN   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SILENCE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POLL    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STOP    = 3'd4;

    // response kinds
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STOP  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_NACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE  = 2'd2;

    localparam logic [GAP_W-1:0]   GAP_RST   = 8'd20;
    localparam logic [BURST_W-1:0] BURST_RST = 5'd5;
    localparam logic [SIL_W-1:0]   SIL_RST   = 16'd100;
    localparam logic [BURST_W-1:0] BURST_MAX = 5'd16;
    localparam logic [SIL_W-1:0]   SIL_SAT   = 16'hFFFF;

    typedef struct packed {
        logic [GAP_W-1:0]   gap_nack_limit;
        logic [BURST_W-1:0] burst_limit;
        logic [SIL_W-1:0]   silence_limit;
    } cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SEQ_W-1:0]    seq;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic              last;
        logic              ovf;
    } result_t;

endpackage

/* design/log_block_ack_nack_receiver.sv */
// Top level of the log block ack/nack receiver: configuration registers,
// front end, command queue and back end. Depends on lbanr_pkg, lbanr_front, lbanr_back.
//
// Receiver side of a numbered-block log transfer. Input beats enter through a
// push/full queue interface and are decoded by the front end into a two-entry
// command queue; the back end works through one command at a time and writes
// responses into a two-beat result buffer read through empty/pop. Under the single
// back-end sequencer, a data block queues its ack, then a nack for each number
// in the gap (at most 254); a drain reads each response through the registered
// read of the response RAM and writes it out, up to 16 per drain; a poll outside
// a session writes a stop and/or start beat; silence ticks and stop requests are
// handled in the idle state, and unknown actions are dropped by the front without
// reaching the back end. The front registers each command in its queue, and a
// full result buffer stalls the back end only where it has a result beat to write.
// Responses that find the QUEUE_DEPTH-entry response queue full are dropped and
// set the sticky queue_overflowed flag, which only reset clears. Configuration
// must be written while the block is idle.
module log_block_ack_nack_receiver
    import lbanr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input beats
    input  logic                  push,
    output logic                  full,
    input  logic [ACTION_W-1:0]   action,
    input  logic [SEQ_W-1:0]      block_seqno,
    // result beats
    output logic                  empty,
    input  logic                  pop,
    output logic [KIND_W-1:0]     kind,
    output logic [SEQ_W-1:0]      resp_seqno,
    output logic                  last,
    output logic                  queue_overflowed,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    cmd_valid, cmd_pop;
    cmd_t    cmd;
    result_t res;

    // register writes; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_nack_limit <= GAP_RST;
            cfg_reg.burst_limit    <= BURST_RST;
            cfg_reg.silence_limit  <= SIL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAP_NACK: cfg_reg.gap_nack_limit <= cfg_data[GAP_W-1:0];
                CFG_BURST:    cfg_reg.burst_limit    <= cfg_data[BURST_W-1:0];
                CFG_SILENCE:  cfg_reg.silence_limit  <= cfg_data[SIL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    lbanr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .action      (action),
        .block_seqno (block_seqno),
        .full        (full),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    lbanr_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_empty (empty),
        .res_pop   (pop)
    );

    assign kind             = res.kind;
    assign resp_seqno       = res.seq;
    assign last             = res.last;
    assign queue_overflowed = res.ovf;

endmodule

/* design/lbanr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the response queue of the receiver.
module lbanr_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/lbanr_front.sv */
// Front end: takes input beats, drops unknown actions, queues commands.
// Depends on lbanr_pkg.
module lbanr_front
    import lbanr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [ACTION_W-1:0] action,
    input  logic [SEQ_W-1:0]    block_seqno,
    output logic                full,
    output logic                cmd_valid,
    output cmd_t                cmd,
    input  logic                cmd_pop
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept, keep, take;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    assign accept = push && !full;
    // actions above stop are accepted and dropped here
    assign keep   = accept && (action <= ACT_STOP);
    assign take   = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = keep ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (keep && !take)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (take && !keep)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            slot_reg[wr_ptr_reg] <= '{action: action, seq: block_seqno};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* design/lbanr_back.sv */
// Back end: session state, response queue in RAM, drain and poll sequencing,
// and a two-beat result buffer. Depends on lbanr_pkg, lbanr_ram and the macros.
`include "log_block_ack_nack_receiver_macros.svh"

module lbanr_back
    import lbanr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output result_t res,
    output logic    res_empty,
    input  logic    res_pop
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int RESP_W = SEQ_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_DATA       = 3'd1;
    localparam logic [2:0] ST_NACK       = 3'd2;
    localparam logic [2:0] ST_DRAIN      = 3'd3;
    localparam logic [2:0] ST_DRAIN_OUT  = 3'd4;
    localparam logic [2:0] ST_POLL_STOP  = 3'd5;
    localparam logic [2:0] ST_POLL_START = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic              active_reg, active_next;
    logic              seen_reg, seen_next;
    logic [SEQ_W-1:0]  highest_reg, highest_next;
    logic [SIL_W-1:0]  silence_reg, silence_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [SEQ_W-1:0]  nack_reg, nack_next;
    logic [BURST_W-1:0] limit_reg, limit_next;
    logic [BURST_W-1:0] sent_reg, sent_next;
    logic              dlast_reg, dlast_next;

    result_t           ob_slot_reg [2];
    logic              ob_wr_reg, ob_rd_reg;
    logic [1:0]        ob_cnt_reg;
    logic              ob_push, ob_take, ob_space;
    result_t           ob_data;

    logic              enq_valid, enq_ack;
    logic [SEQ_W-1:0]  enq_seq;
    logic              ram_we, ram_re;
    logic [RESP_W-1:0] ram_rdata;

    logic [SEQ_W-1:0]  gap, first_nack, nack_inc;
    logic              fwd, nack_ok;
    logic [SIL_W-1:0]  sil_inc;
    logic [BURST_W-1:0] burst_eff, sent_inc;

    assign gap        = seq_reg - highest_reg;
    assign fwd        = seq_reg > highest_reg;
    assign nack_ok    = fwd && (gap <= {{(SEQ_W-GAP_W){1'b0}}, cfg.gap_nack_limit});
    assign first_nack = highest_reg + 32'd1;
    assign nack_inc   = nack_reg + 32'd1;
    assign sil_inc    = (silence_reg != SIL_SAT) ? silence_reg + 16'd1 : silence_reg;
    assign burst_eff  = (cfg.burst_limit > BURST_MAX) ? BURST_MAX : cfg.burst_limit;
    assign sent_inc   = sent_reg + 5'd1;
    assign ob_space   = (ob_cnt_reg != 2'd2);

    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        seen_next    = seen_reg;
        highest_next = highest_reg;
        silence_next = silence_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        seq_next     = seq_reg;
        nack_next    = nack_reg;
        limit_next   = limit_reg;
        sent_next    = sent_reg;
        dlast_next   = dlast_reg;
        cmd_pop      = 1'b0;
        enq_valid    = 1'b0;
        enq_ack      = 1'b0;
        enq_seq      = seq_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ob_push      = 1'b0;
        ob_data      = '{kind: KIND_ACK, seq: '0, last: 1'b0, ovf: ovf_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    seq_next = cmd.seq;
                    unique case (cmd.action)
                        ACT_DATA:
                        begin
                            state_next = ST_DATA;
                        end
                        ACT_DRAIN:
                        begin
                            limit_next = burst_eff;
                            sent_next  = '0;
                            state_next = ST_DRAIN;
                        end
                        ACT_SILENCE:
                        begin
                            if (active_reg)
                            begin
                                if (sil_inc >= cfg.silence_limit)
                                begin
                                    active_next  = 1'b0;
                                    silence_next = '0;
                                end
                                else
                                begin
                                    silence_next = sil_inc;
                                end
                            end
                        end
                        ACT_POLL:
                        begin
                            if (!active_reg)
                            begin
                                state_next = seen_reg ? ST_POLL_STOP : ST_POLL_START;
                            end
                        end
                        ACT_STOP:
                        begin
                            if (active_reg)
                            begin
                                active_next  = 1'b0;
                                silence_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DATA:
            begin
                if (!active_reg && (seq_reg != '0))
                begin
                    // outside a session only block zero counts
                    state_next = ST_IDLE;
                end
                else
                begin
                    active_next  = 1'b1;
                    seen_next    = 1'b1;
                    enq_valid    = 1'b1;
                    enq_ack      = 1'b1;
                    enq_seq      = seq_reg;
                    silence_next = '0;
                    nack_next    = first_nack;
                    if (fwd)
                    begin
                        highest_next = seq_reg;
                    end
                    state_next = (nack_ok && (first_nack != seq_reg)) ? ST_NACK : ST_IDLE;
                end
            end
            ST_NACK:
            begin
                enq_valid = 1'b1;
                enq_ack   = 1'b0;
                enq_seq   = nack_reg;
                nack_next = nack_inc;
                if (nack_inc == seq_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if ((count_reg == '0) || (sent_reg == limit_reg))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    dlast_next = (sent_inc == limit_reg) || (count_reg == CNT_W'(1));
                    state_next = ST_DRAIN_OUT;
                end
            end
            ST_DRAIN_OUT:
            begin
                if (ob_space)
                begin
                    ob_push    = 1'b1;
                    ob_data    = '{kind: ram_rdata[SEQ_W] ? KIND_ACK : KIND_NACK,
                                   seq:  ram_rdata[SEQ_W-1:0],
                                   last: dlast_reg,
                                   ovf:  ovf_reg};
                    tail_next  = (tail_reg == LAST_PTR) ? '0 : tail_reg + PTR_W'(1);
                    count_next = count_reg - CNT_W'(1);
                    sent_next  = sent_inc;
                    state_next = ST_DRAIN;
                end
            end
            ST_POLL_STOP:
            begin
                if (ob_space)
                begin
                    ob_push    = 1'b1;
                    ob_data    = '{kind: KIND_STOP, seq: '0, last: 1'b0, ovf: ovf_reg};
                    state_next = ST_POLL_START;
                end
            end
            ST_POLL_START:
            begin
                if (ob_space)
                begin
                    ob_push    = 1'b1;
                    ob_data    = '{kind: KIND_START, seq: '0, last: 1'b1, ovf: ovf_reg};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // enqueue never coincides with a dequeue
        if (enq_valid)
        begin
            if (count_reg == DEPTH_CNT)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                ram_we     = 1'b1;
                head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    lbanr_ram #(
        .WIDTH (RESP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_resp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata ({enq_ack, enq_seq}),
        .re    (ram_re),
        .raddr (tail_reg),
        .rdata (ram_rdata)
    );

    // result buffer
    assign res_empty = (ob_cnt_reg == 2'd0);
    assign res       = ob_slot_reg[ob_rd_reg];
    assign ob_take   = res_pop && !res_empty;

    always_ff @(posedge clk)
    begin
        if (ob_push)
        begin
            ob_slot_reg[ob_wr_reg] <= ob_data;
        end
        seq_reg   <= seq_next;
        nack_reg  <= nack_next;
        limit_reg <= limit_next;
        sent_reg  <= sent_next;
        dlast_reg <= dlast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            seen_reg    <= 1'b0;
            highest_reg <= '0;
            silence_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            ob_wr_reg   <= 1'b0;
            ob_rd_reg   <= 1'b0;
            ob_cnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            seen_reg    <= seen_next;
            highest_reg <= highest_next;
            silence_reg <= silence_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            if (ob_push)
            begin
                ob_wr_reg <= ~ob_wr_reg;
            end
            if (ob_take)
            begin
                ob_rd_reg <= ~ob_rd_reg;
            end
            if (ob_push && !ob_take)
            begin
                ob_cnt_reg <= ob_cnt_reg + 2'd1;
            end
            else if (ob_take && !ob_push)
            begin
                ob_cnt_reg <= ob_cnt_reg - 2'd1;
            end
        end
    end

    `LBANR_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_CNT)
    `LBANR_ASSERT_IMP(a_read_nonempty, clk, rst_n, ram_re, count_reg != '0)
    `LBANR_ASSERT_NEXT(a_ovf_sticky, clk, rst_n, ovf_reg, ovf_reg)
    `LBANR_ASSERT_IMP(a_active_seen, clk, rst_n, active_reg, seen_reg)
    `LBANR_ASSERT_IMP(a_ob_no_overrun, clk, rst_n, ob_push, ob_cnt_reg != 2'd2)

endmodule

/* sim/tb_log_block_ack_nack_receiver.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the log block ack/nack receiver.
// Depends on lbanr_pkg and log_block_ack_nack_receiver. The scoreboard tracks
// session, gap and response-queue state and checks each result beat in order.
module tb_log_block_ack_nack_receiver;
    import lbanr_pkg::*;

    localparam int Q_DEPTH        = 64;
    localparam int MAX_BURST      = 16;
    // Longest back-end job is a data block nacking a 255 gap; allow for it.
    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    // Actions the block does not decode; they must be swallowed silently.
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

    // Receiver stall patterns.
    typedef enum int {POP_STEADY, POP_LIGHT, POP_EVERY_THIRD, POP_HEAVY} stall_e;

    // One slot of the response ring: number plus ack/nack bit.
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic             is_ack;
    } ring_slot_t;

    // ------------------------------------------------------------------
    // Scoreboard: mirror of the receiver state plus the expected beats.
    // ------------------------------------------------------------------
    class response_scoreboard;
        cfg_t             regs;
        logic             in_session;
        logic             had_session;
        logic             ovf_flag;
        logic [SEQ_W-1:0] highest;
        logic [SIL_W-1:0] quiet_ticks;
        ring_slot_t       ring [Q_DEPTH];
        int               head;
        int               tail;
        int               count;
        result_t          expected_responses [$];
        int               errors;

        function new();
            regs.gap_nack_limit = GAP_RST;
            regs.burst_limit    = BURST_RST;
            regs.silence_limit  = SIL_RST;
            in_session  = 1'b0;
            had_session = 1'b0;
            ovf_flag    = 1'b0;
            highest     = '0;
            quiet_ticks = '0;
            head        = 0;
            tail        = 0;
            count       = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_GAP_NACK: regs.gap_nack_limit = value[GAP_W-1:0];
                CFG_BURST:    regs.burst_limit    = value[BURST_W-1:0];
                CFG_SILENCE:  regs.silence_limit  = value[SIL_W-1:0];
                default: ;
            endcase
        endfunction

        // A full ring drops the response and latches the sticky flag.
        function void ring_put(logic [SEQ_W-1:0] seq, logic is_ack);
            if (count >= Q_DEPTH) begin
                ovf_flag = 1'b1;
            end
            else begin
                ring[head].seq    = seq;
                ring[head].is_ack = is_ack;
                head  = (head + 1) % Q_DEPTH;
                count = count + 1;
            end
        endfunction

        function void end_session();
            in_session  = 1'b0;
            quiet_ticks = '0;
        endfunction

        // Called once per accepted input beat; queues the result beats it causes.
        function void note_beat(logic [ACTION_W-1:0] act, logic [SEQ_W-1:0] seq);
            result_t          beats [MAX_BURST];
            int               n;
            int               lim;
            logic [SEQ_W-1:0] k;
            n = 0;
            case (act)
                ACT_DATA:
                begin
                    if (!in_session && seq != '0)
                        return;
                    if (!in_session)
                    begin
                        in_session  = 1'b1;
                        had_session = 1'b1;
                    end
                    ring_put(seq, 1'b1);
                    if (seq > highest)
                    begin
                        if ((seq - highest) <= regs.gap_nack_limit)
                            for (k = highest + 1; k < seq; k++)
                                ring_put(k, 1'b0);
                        highest = seq;
                    end
                    quiet_ticks = '0;
                end
                ACT_DRAIN:
                begin
                    lim = (regs.burst_limit > BURST_MAX) ? BURST_MAX : regs.burst_limit;
                    while (count > 0 && n < lim)
                    begin
                        beats[n].kind = ring[tail].is_ack ? KIND_ACK : KIND_NACK;
                        beats[n].seq  = ring[tail].seq;
                        beats[n].last = 1'b0;
                        beats[n].ovf  = ovf_flag;
                        n     = n + 1;
                        tail  = (tail + 1) % Q_DEPTH;
                        count = count - 1;
                    end
                end
                ACT_SILENCE:
                begin
                    if (in_session)
                    begin
                        if (quiet_ticks < SIL_SAT)
                            quiet_ticks = quiet_ticks + 1'b1;
                        if (quiet_ticks >= regs.silence_limit)
                            end_session();
                    end
                end
                ACT_POLL:
                begin
                    if (!in_session)
                    begin
                        if (had_session)
                        begin
                            beats[n] = '{kind: KIND_STOP, seq: '0, last: 1'b0, ovf: ovf_flag};
                            n = n + 1;
                        end
                        beats[n] = '{kind: KIND_START, seq: '0, last: 1'b0, ovf: ovf_flag};
                        n = n + 1;
                    end
                end
                ACT_STOP:
                begin
                    if (in_session)
                        end_session();
                end
                default: ;
            endcase
            if (n > 0)
                beats[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
                expected_responses.push_back(beats[i]);
        endfunction

        function void check_beat(logic [KIND_W-1:0] got_kind, logic [SEQ_W-1:0] got_seq,
                                 logic got_last, logic got_ovf);
            result_t want;
            if (expected_responses.size() == 0)
            begin
                $error("unexpected result beat: kind %0d resp_seqno 0x%08h", got_kind, got_seq);
                errors++;
                return;
            end
            want = expected_responses.pop_front();
            if (got_kind !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, got_kind);
                errors++;
            end
            if (got_seq !== want.seq)
            begin
                $error("resp_seqno: expected 0x%08h, actual 0x%08h", want.seq, got_seq);
                errors++;
            end
            if (got_last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, got_last);
                errors++;
            end
            if (got_ovf !== want.ovf)
            begin
                $error("queue_overflowed: expected %0b, actual %0b", want.ovf, got_ovf);
                errors++;
            end
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Everything starts at a known value.
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [ACTION_W-1:0]   action = ACT_DATA;
    logic [SEQ_W-1:0]      block_seqno = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [KIND_W-1:0]     kind;
    logic [SEQ_W-1:0]      resp_seqno;
    logic                  last;
    logic                  queue_overflowed;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_GAP_NACK;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    response_scoreboard sb;

    // Sender burst bookkeeping and random-stimulus knobs.
    int     burst_left = 0;
    int     quiet_run = 0;
    bit     allow_overflow = 1'b0;
    int     idle_cycles = 0;

    // Receiver stall pattern state.
    stall_e pop_mode = POP_STEADY;
    int     pop_mode_left = 0;
    int     pop_phase = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    log_block_ack_nack_receiver #(
        .QUEUE_DEPTH      (Q_DEPTH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .action           (action),
        .block_seqno      (block_seqno),
        .empty            (empty),
        .pop              (pop),
        .kind             (kind),
        .resp_seqno       (resp_seqno),
        .last             (last),
        .queue_overflowed (queue_overflowed),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // ------------------------------------------------------------------
    // Result side: pop follows a stall pattern, picked anew at random:
    // steady draining, light and heavy random stalls and a fixed
    // one-in-three cadence. Beats are checked on the edge they
    // are taken, reading the values the DUT saw before that edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (pop_mode_left == 0)
        begin
            pop_mode      = stall_e'($urandom_range(POP_STEADY, POP_HEAVY));
            pop_mode_left = $urandom_range(20, 200);
        end
        pop_mode_left--;
        pop_phase = (pop_phase + 1) % 3;
        case (pop_mode)
            POP_STEADY:      pop <= 1'b1;
            POP_LIGHT:       pop <= ($urandom_range(0, 3) != 0);
            POP_EVERY_THIRD: pop <= (pop_phase == 0);
            default:         pop <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
        if (rst_n && pop && !empty)
            sb.check_beat(kind, resp_seqno, last, queue_overflowed);

    // Watchdog: any beat or register write counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------

    // Present one input beat and hold it until taken. Beats go out in bursts
    // with random gaps between them; a zero gap gives back-to-back bursts.
    task automatic send_item(logic [ACTION_W-1:0] act, logic [SEQ_W-1:0] seq);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push        <= 1'b1;
        action      <= act;
        block_seqno <= seq;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_beat(act, seq);
    endtask

    // Stop sending, let every expected beat arrive, then give the back end
    // time to finish any data block still nacking (those emit nothing).
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges; only done while idle.
    task automatic program_regs(logic [CFG_DATA_W-1:0] gap_lim,
                                logic [CFG_DATA_W-1:0] burst_lim,
                                logic [CFG_DATA_W-1:0] quiet_lim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GAP_NACK;
        cfg_data  <= gap_lim;
        @(posedge clk);
        sb.write_reg(CFG_GAP_NACK, gap_lim);
        cfg_index <= CFG_BURST;
        cfg_data  <= burst_lim;
        @(posedge clk);
        sb.write_reg(CFG_BURST, burst_lim);
        cfg_index <= CFG_SILENCE;
        cfg_data  <= quiet_lim;
        @(posedge clk);
        sb.write_reg(CFG_SILENCE, quiet_lim);
        cfg_we <= 1'b0;
    endtask

    // Choose the next random beat from the mirrored state. Outside a session
    // most beats open one with block 0; inside, the largest share are blocks
    // just ahead of the highest number so the nack path is exercised, mixed with
    // drains, silence runs, stops, polls, back-fills, big jumps and junk actions.
    // 'counts' is clear for beats the block merely throws away.
    task automatic pick_item(output logic [ACTION_W-1:0] act,
                             output logic [SEQ_W-1:0] seq, output bit counts);
        int               roll;
        int               reach;
        int               quiet_cap;
        logic [SEQ_W-1:0] hi;
        roll      = $urandom_range(0, 99);
        hi        = sb.highest;
        seq       = $urandom();
        counts    = 1'b1;
        quiet_cap = (sb.regs.silence_limit > 6) ? 6 : sb.regs.silence_limit;
        reach     = sb.regs.gap_nack_limit + 3;
        if (allow_overflow && $urandom_range(0, 3) == 0)
            reach = 258;
        else if (reach > 24)
            reach = 24;

        if (quiet_run > 0)
        begin
            quiet_run--;
            act = ACT_SILENCE;
        end
        else if (!sb.in_session)
        begin
            if (roll < 55)
            begin
                act = ACT_DATA;
                seq = '0;
            end
            else if (roll < 70)
                act = ACT_POLL;
            else if (roll < 80)
            begin
                // stray block while idle: ignored unless it happens to be 0
                act    = ACT_DATA;
                counts = (seq == '0);
            end
            else if (roll < 88)
                act = ACT_DRAIN;
            else if (roll < 96)
            begin
                act    = (roll < 92) ? ACT_SILENCE : ACT_STOP;
                counts = 1'b0;
            end
            else
            begin
                act    = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
                counts = 1'b0;
            end
        end
        else if (!allow_overflow && sb.count > 40)
            act = ACT_DRAIN;   // keep the ring clear of overflow until that phase
        else if (roll < 50)
        begin
            act = ACT_DATA;
            seq = (hi > 32'hFFFF_0000) ? hi : hi + $urandom_range(1, reach);
        end
        else if (roll < 56)
        begin
            // duplicate or back-filling block
            act = ACT_DATA;
            seq = (hi > 8) ? hi - $urandom_range(0, 8) : $urandom_range(0, hi);
        end
        else if (roll < 59)
        begin
            // gap well past any limit: ack only, highest still moves
            act = ACT_DATA;
            seq = (hi > 32'hFFFF_0000) ? hi : hi + $urandom_range(300, 5000);
        end
        else if (roll < 78)
            act = ACT_DRAIN;
        else if (roll < 90)
        begin
            act       = ACT_SILENCE;
            quiet_run = $urandom_range(0, quiet_cap);
        end
        else if (roll < 93)
            act = ACT_STOP;
        else if (roll < 96)
            act = ACT_POLL;
        else
        begin
            act    = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            counts = 1'b0;
        end
    endtask

    task automatic run_random(int n_items);
        logic [ACTION_W-1:0] act;
        logic [SEQ_W-1:0]    seq;
        bit                  counts;
        int                  done;
        done      = 0;
        quiet_run = 0;
        while (done < n_items)
        begin
            pick_item(act, seq, counts);
            send_item(act, seq);
            if (counts)
                done++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset register values (gap 20, burst 5, silence 100).
        send_item(ACT_POLL, '0);                // no session yet: start only
        send_item(ACT_DATA, 32'd5);             // idle, non-zero block: dropped
        send_item(ACT_DATA, 32'hFFFF_FFFF);     // idle, all-ones block: dropped
        send_item(ACT_SILENCE, '0);             // idle silence tick: dropped
        send_item(ACT_STOP, '0);                // idle stop: dropped
        send_item(ACT_DATA, '0);                // opens the session
        send_item(ACT_POLL, '0);                // poll inside session: dropped
        send_item(ACT_DATA, 32'd1);
        send_item(ACT_DATA, 32'd4);             // nacks 2 and 3
        send_item(ACT_DATA, 32'd3);             // back-fill: ack only
        send_item(ACT_DATA, 32'd4);             // duplicate: ack only
        send_item(ACT_DATA, 32'd30);            // gap 26 over limit: ack only
        send_item(ACT_DATA, 32'd50);            // gap exactly at limit: 19 nacks
        repeat (6) send_item(ACT_DRAIN, '0);    // 28 queued, five per drain
        send_item(ACT_UNUSED_LO, 32'hA5A5_5A5A);
        send_item(ACT_UNUSED_LO + 3'd1, '0);
        send_item(ACT_UNUSED_HI, 32'hFFFF_FFFF);
        send_item(ACT_SILENCE, '0);             // below the silence limit
        send_item(ACT_STOP, '0);                // ends the session quietly
        send_item(ACT_POLL, '0);                // stop then start
        send_item(ACT_DRAIN, '0);               // empty ring: nothing
        wait_idle();

        // Low extremes: no nacks at all, single-beat drains, one-tick silence.
        program_regs(16'd0, 16'd1, 16'd1);
        run_random(40);
        wait_idle();

        // Burst above sixteen clamps, silence limit zero ends on first tick.
        program_regs(16'd7, 16'd31, 16'd0);
        run_random(40);
        wait_idle();

        // Burst zero: drains return nothing, only polls produce beats.
        program_regs(16'd20, 16'd0, 16'd3);
        run_random(20);
        wait_idle();

        // Middle-of-the-road random setting.
        program_regs($urandom_range(1, 30), $urandom_range(2, 15), $urandom_range(2, 12));
        run_random(80);
        wait_idle();

        // High extremes: gaps up to 255 overrun the 64-entry ring and set
        // the sticky overflow flag, which then shows on every later beat.
        allow_overflow = 1'b1;
        program_regs(16'd255, 16'd16, 16'd65535);
        run_random(65);

        // Close with the top of the number space.
        send_item(ACT_STOP, '0);
        while (sb.count > 0)
            send_item(ACT_DRAIN, '0);
        send_item(ACT_DATA, '0);
        send_item(ACT_DATA, 32'hFFFF_FFF0);     // huge jump: ack only
        send_item(ACT_DATA, 32'hFFFF_FFFF);     // gap 15: 14 nacks
        send_item(ACT_DRAIN, '0);
        send_item(ACT_DRAIN, '0);
        send_item(ACT_POLL, '0);
        send_item(ACT_STOP, '0);
        send_item(ACT_POLL, '0);
        wait_idle();

        if (sb.pending() != 0)
        begin
            $error("%0d expected result beats never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
